/* src/sqvg_pkg.sv */
// ----------------------------------------------------------------------------
// Sprite quad vertex generator package
// Shared constants, widths and the queue word that links the front and the
// back half of the generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sqvg_pkg;

	// Texture slot table depth that the top level uses unless told otherwise.
	localparam int SLOT_COUNT_DEF = 8;

	// Field widths fixed by the interface.
	localparam int POS_W      = 16;
	localparam int TEX_W      = 16;
	localparam int RGBA_W     = 32;
	localparam int SAT_W      = 8;
	localparam int ID_W       = 32;
	localparam int SLOT_OUT_W = 4;
	localparam int CNT_W      = 11;
	localparam int VIDX_W     = 12;
	localparam int CORNER_W   = 2;
	localparam int BASE_W     = VIDX_W - CORNER_W;

	// Sprite count limit after reset.
	localparam logic [CNT_W-1:0] MAX_SPRITES_RST = 11'd1024;

	// Slot code reported when the texture table has no room left.
	localparam logic [SLOT_OUT_W-1:0] SLOT_NONE = '1;
	// Slot reserved for untextured sprites.
	localparam logic [SLOT_OUT_W-1:0] SLOT_UNTEX = '0;

	// Corner numbers, counter-clockwise from the origin.
	localparam logic [CORNER_W-1:0] CORNER_00 = 2'd0;
	localparam logic [CORNER_W-1:0] CORNER_10 = 2'd1;
	localparam logic [CORNER_W-1:0] CORNER_11 = 2'd2;
	localparam logic [CORNER_W-1:0] CORNER_01 = 2'd3;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// One classified sprite, as handed from the front to the back.
	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] size_x;
		logic signed [POS_W-1:0] size_y;
		logic [RGBA_W-1:0]       rgba;
		logic [SAT_W-1:0]        sat;
		logic [TEX_W-1:0]        tex_u;
		logic [TEX_W-1:0]        tex_v;
		logic [TEX_W-1:0]        tex_w;
		logic [TEX_W-1:0]        tex_h;
		logic [SLOT_OUT_W-1:0]   slot;
		logic [BASE_W-1:0]       base;
		logic                    full;
	} sqvg_entry_t;

endpackage

`default_nettype wire

/* src/sprite_quad_vertex_generator_unit.sv */
// ----------------------------------------------------------------------------
// Sprite quad vertex generator
// Turns each sprite into the four corners of its quad, with texture slot
// binding, vertex numbering and a batch full flag.
// ----------------------------------------------------------------------------
// A taken sprite word is written into the queue, and from there its corners
// are registered into the output stage one per cycle while out_ready holds.
// The single output port carries one corner per cycle, so each sprite takes
// four output words. Up to two sprites wait in the queue.
// Reset: arst_n clears the texture slot count to one, the sprite count to
// zero, the limit to 1024, and empties queue and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_quad_vertex_generator_unit #(
	parameter int SLOT_COUNT = sqvg_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Sprite limit register.
	input  wire logic                                   cfg_we,
	input  wire logic [sqvg_pkg::CNT_W-1:0]             cfg_wdata,
	// Sprite words in.
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [sqvg_pkg::POS_W-1:0]      pos_x,
	input  wire logic signed [sqvg_pkg::POS_W-1:0]      pos_y,
	input  wire logic signed [sqvg_pkg::POS_W-1:0]      size_x,
	input  wire logic signed [sqvg_pkg::POS_W-1:0]      size_y,
	input  wire logic [sqvg_pkg::RGBA_W-1:0]            rgba,
	input  wire logic [sqvg_pkg::SAT_W-1:0]             sat,
	input  wire logic [sqvg_pkg::TEX_W-1:0]             tex_u,
	input  wire logic [sqvg_pkg::TEX_W-1:0]             tex_v,
	input  wire logic [sqvg_pkg::TEX_W-1:0]             tex_w,
	input  wire logic [sqvg_pkg::TEX_W-1:0]             tex_h,
	input  wire logic [sqvg_pkg::ID_W-1:0]              tex_handle,
	input  wire logic                                   untextured,
	// Vertex words out.
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [sqvg_pkg::POS_W-1:0]           vert_x,
	output logic signed [sqvg_pkg::POS_W-1:0]           vert_y,
	output logic [sqvg_pkg::RGBA_W-1:0]                 vert_rgba,
	output logic [sqvg_pkg::SAT_W-1:0]                  vert_sat,
	output logic [sqvg_pkg::TEX_W-1:0]                  vert_u,
	output logic [sqvg_pkg::TEX_W-1:0]                  vert_v,
	output logic signed [sqvg_pkg::SLOT_OUT_W-1:0]      slot,
	output logic [sqvg_pkg::VIDX_W-1:0]                 vertex_index,
	output logic                                        batch_full,
	output logic                                        last
);
	import sqvg_pkg::*;

	// The front end does all per-sprite bookkeeping at the moment the word is
	// taken, so sprite after sprite may enter on consecutive cycles as long as
	// the queue has room. Each queue word is complete in itself.
	logic        push_valid;
	logic        push_ready;
	sqvg_entry_t push_data;

	// The back end only expands queue words into corners.
	logic        pop_valid;
	logic        pop_ready;
	sqvg_entry_t pop_data;

	sqvg_front #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.size_x     (size_x),
		.size_y     (size_y),
		.rgba       (rgba),
		.sat        (sat),
		.tex_u      (tex_u),
		.tex_v      (tex_v),
		.tex_w      (tex_w),
		.tex_h      (tex_h),
		.tex_handle (tex_handle),
		.untextured (untextured),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sqvg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The output stage is a register, so a stalled vertex word never blocks
	// the front end from taking new sprites while the queue has room.
	sqvg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vert_x       (vert_x),
		.vert_y       (vert_y),
		.vert_rgba    (vert_rgba),
		.vert_sat     (vert_sat),
		.vert_u       (vert_u),
		.vert_v       (vert_v),
		.slot         (slot),
		.vertex_index (vertex_index),
		.batch_full   (batch_full),
		.last         (last)
	);

endmodule

`default_nettype wire

/* src/sqvg_front.sv */
// ----------------------------------------------------------------------------
// Sprite quad vertex generator front end
// Accepts sprites, binds their texture ids to slots, advances the sprite
// counter and pushes one classified word per sprite into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvg_front #(
	parameter int SLOT_COUNT = sqvg_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [sqvg_pkg::CNT_W-1:0]        cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [sqvg_pkg::POS_W-1:0] pos_x,
	input  wire logic signed [sqvg_pkg::POS_W-1:0] pos_y,
	input  wire logic signed [sqvg_pkg::POS_W-1:0] size_x,
	input  wire logic signed [sqvg_pkg::POS_W-1:0] size_y,
	input  wire logic [sqvg_pkg::RGBA_W-1:0]       rgba,
	input  wire logic [sqvg_pkg::SAT_W-1:0]        sat,
	input  wire logic [sqvg_pkg::TEX_W-1:0]        tex_u,
	input  wire logic [sqvg_pkg::TEX_W-1:0]        tex_v,
	input  wire logic [sqvg_pkg::TEX_W-1:0]        tex_w,
	input  wire logic [sqvg_pkg::TEX_W-1:0]        tex_h,
	input  wire logic [sqvg_pkg::ID_W-1:0]         tex_handle,
	input  wire logic                              untextured,
	output logic                                   push_valid,
	input  wire logic                              push_ready,
	output sqvg_pkg::sqvg_entry_t                  push_data
);
	import sqvg_pkg::*;

	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int USED_W = $clog2(SLOT_COUNT + 1);

	logic [ID_W-1:0]       bound_q [SLOT_COUNT];
	logic [USED_W-1:0]     used_q;
	logic [CNT_W-1:0]      sprites_q;
	logic [CNT_W-1:0]      max_q;

	logic                  accept;
	logic                  hit;
	logic [SLOT_W-1:0]     hit_idx;
	logic                  room;
	logic                  bind_new;
	logic [SLOT_OUT_W-1:0] slot_sel;
	logic [CNT_W-1:0]      sprites_nxt;

	assign accept = in_valid && in_ready;
	assign in_ready = push_ready;
	assign push_valid = in_valid;

	// Entry 0 is reserved and never compared. Bound ids are unique, so at
	// most one entry matches and the index can be gathered with an OR.
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int i = 1; i < SLOT_COUNT; i++) begin
			if ((USED_W'(i) < used_q) && (bound_q[i] == tex_handle)) begin
				hit = 1'b1;
				hit_idx = hit_idx | SLOT_W'(i);
			end
		end
	end

	assign room = used_q < USED_W'(SLOT_COUNT);
	assign bind_new = accept && !untextured && !hit && room;

	always_comb begin
		if (untextured) begin
			slot_sel = SLOT_UNTEX;
		end else if (hit) begin
			slot_sel = SLOT_OUT_W'(hit_idx);
		end else if (room) begin
			slot_sel = SLOT_OUT_W'(used_q);
		end else begin
			slot_sel = SLOT_NONE;
		end
	end

	assign sprites_nxt = (sprites_q < max_q) ? sprites_q + CNT_W'(1) : sprites_q;

	always_comb begin
		push_data.pos_x  = pos_x;
		push_data.pos_y  = pos_y;
		push_data.size_x = size_x;
		push_data.size_y = size_y;
		push_data.rgba   = rgba;
		push_data.sat    = sat;
		push_data.tex_u  = tex_u;
		push_data.tex_v  = tex_v;
		push_data.tex_w  = tex_w;
		push_data.tex_h  = tex_h;
		push_data.slot   = slot_sel;
		push_data.base   = sprites_q[BASE_W-1:0];
		push_data.full   = sprites_nxt >= max_q;
	end

	always_ff @(posedge clk) begin
		if (bind_new) begin
			bound_q[used_q[SLOT_W-1:0]] <= tex_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= USED_W'(1);
			sprites_q <= '0;
			max_q <= MAX_SPRITES_RST;
		end else begin
			if (bind_new) begin
				used_q <= used_q + USED_W'(1);
			end
			if (accept) begin
				sprites_q <= sprites_nxt;
			end
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
		end
	end

	// The slot fill count stays between the reserved slot and the table size.
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q >= USED_W'(1)) && (used_q <= USED_W'(SLOT_COUNT)))
		else $error("slot fill count out of range");

	// A sprite below the limit advances the counter by exactly one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (sprites_q < max_q) |=> sprites_q == $past(sprites_q) + CNT_W'(1))
		else $error("sprite counter did not advance");

endmodule

`default_nettype wire

/* src/sqvg_queue.sv */
// ----------------------------------------------------------------------------
// Sprite quad vertex generator queue
// Short first-in first-out buffer of classified sprite words between the
// front end and the corner generator.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvg_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push_valid,
	output logic                       push_ready,
	input  wire sqvg_pkg::sqvg_entry_t push_data,
	output logic                       pop_valid,
	input  wire logic                  pop_ready,
	output sqvg_pkg::sqvg_entry_t      pop_data
);
	import sqvg_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	sqvg_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = fill_q < FILL_W'(QUEUE_DEPTH);
	assign pop_valid = fill_q != '0;
	assign pop_data = mem_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + FILL_W'(1);
				2'b01:   fill_q <= fill_q - FILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Pointers and fill count must agree: equal pointers mean empty or full.
	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_q == rd_q) |-> ((fill_q == '0) || (fill_q == FILL_W'(QUEUE_DEPTH))))
		else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

/* src/sqvg_back.sv */
// ----------------------------------------------------------------------------
// Sprite quad vertex generator back end
// Walks the four corners of the sprite at the queue head and registers one
// saturated vertex word per cycle into the output stage while it is empty or draining.
// ----------------------------------------------------------------------------
`default_nettype none

module sqvg_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               pop_valid,
	output logic                                    pop_ready,
	input  wire sqvg_pkg::sqvg_entry_t              pop_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [sqvg_pkg::POS_W-1:0]       vert_x,
	output logic signed [sqvg_pkg::POS_W-1:0]       vert_y,
	output logic [sqvg_pkg::RGBA_W-1:0]             vert_rgba,
	output logic [sqvg_pkg::SAT_W-1:0]              vert_sat,
	output logic [sqvg_pkg::TEX_W-1:0]              vert_u,
	output logic [sqvg_pkg::TEX_W-1:0]              vert_v,
	output logic signed [sqvg_pkg::SLOT_OUT_W-1:0]  slot,
	output logic [sqvg_pkg::VIDX_W-1:0]             vertex_index,
	output logic                                    batch_full,
	output logic                                    last
);
	import sqvg_pkg::*;

	logic [CORNER_W-1:0]    corner_q;
	logic                   out_valid_q;
	logic [POS_W-1:0]       x_q;
	logic [POS_W-1:0]       y_q;
	logic [RGBA_W-1:0]      rgba_q;
	logic [SAT_W-1:0]       sat_q;
	logic [TEX_W-1:0]       u_q;
	logic [TEX_W-1:0]       v_q;
	logic [SLOT_OUT_W-1:0]  slot_q;
	logic [VIDX_W-1:0]      vidx_q;
	logic                   full_q;
	logic                   last_q;

	logic                   load;
	logic                   add_x;
	logic                   add_y;
	logic signed [POS_W:0]  sum_x;
	logic signed [POS_W:0]  sum_y;
	logic [TEX_W:0]         sum_u;
	logic [TEX_W:0]         sum_v;
	logic [POS_W-1:0]       x_nxt;
	logic [POS_W-1:0]       y_nxt;
	logic [TEX_W-1:0]       u_nxt;
	logic [TEX_W-1:0]       v_nxt;

	// A new corner goes out whenever a sprite waits at the queue head and the output stage is empty or draining.
	assign load = pop_valid && (!out_valid_q || out_ready);
	assign pop_ready = load && (corner_q == CORNER_01);

	assign add_x = (corner_q == CORNER_10) || (corner_q == CORNER_11);
	assign add_y = (corner_q == CORNER_11) || (corner_q == CORNER_01);

	always_comb begin
		sum_x = {pop_data.pos_x[POS_W-1], pop_data.pos_x}
			+ (add_x ? {pop_data.size_x[POS_W-1], pop_data.size_x} : '0);
		sum_y = {pop_data.pos_y[POS_W-1], pop_data.pos_y}
			+ (add_y ? {pop_data.size_y[POS_W-1], pop_data.size_y} : '0);
		sum_u = {1'b0, pop_data.tex_u} + (add_x ? {1'b0, pop_data.tex_w} : '0);
		sum_v = {1'b0, pop_data.tex_v} + (add_y ? {1'b0, pop_data.tex_h} : '0);

		// Signed overflow shows as the top two bits of the sum disagreeing.
		if (sum_x[POS_W] != sum_x[POS_W-1]) begin
			x_nxt = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			x_nxt = sum_x[POS_W-1:0];
		end
		if (sum_y[POS_W] != sum_y[POS_W-1]) begin
			y_nxt = sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			y_nxt = sum_y[POS_W-1:0];
		end
		u_nxt = sum_u[TEX_W] ? '1 : sum_u[TEX_W-1:0];
		v_nxt = sum_v[TEX_W] ? '1 : sum_v[TEX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= x_nxt;
			y_q    <= y_nxt;
			rgba_q <= pop_data.rgba;
			sat_q  <= pop_data.sat;
			u_q    <= u_nxt;
			v_q    <= v_nxt;
			slot_q <= pop_data.slot;
			vidx_q <= {pop_data.base, corner_q};
			full_q <= pop_data.full;
			last_q <= corner_q == CORNER_01;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= CORNER_00;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				corner_q <= corner_q + CORNER_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign vert_x       = x_q;
	assign vert_y       = y_q;
	assign vert_rgba    = rgba_q;
	assign vert_sat     = sat_q;
	assign vert_u       = u_q;
	assign vert_v       = v_q;
	assign slot         = slot_q;
	assign vertex_index = vidx_q;
	assign batch_full   = full_q;
	assign last         = last_q;

	// The last flag marks exactly the corner numbered three.
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (last_q == (vidx_q[CORNER_W-1:0] == CORNER_01)))
		else $error("last flag does not match corner number");

endmodule

`default_nettype wire
